### sv/imh_pkg.sv
package imh_pkg;

  // sizes of the element space and of one priority
  localparam int unsigned MAX_ELEMENTS = 1024;
  localparam int unsigned PRIO_BITS    = 32;
  localparam int unsigned ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int unsigned IDX_W        = ADDR_W + 1;

  // operation codes
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_DEC_KEY = 2'd1,
    OP_DEL_MIN = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  // one input request
  typedef struct packed {
    op_e                  op;
    logic [IDX_W-1:0]     element;
    logic [PRIO_BITS-1:0] new_priority;
  } req_t;

  // one result
  typedef struct packed {
    logic                 applied;
    logic [IDX_W-1:0]     min_element;
    logic [PRIO_BITS-1:0] root_priority;
    logic                 is_empty;
    logic [IDX_W-1:0]     removed_element;
    logic [PRIO_BITS-1:0] removed_priority;
    logic [PRIO_BITS-1:0] element_priority;
  } rsp_t;

  // one heap slot: the element that sits there and its priority
  typedef struct packed {
    logic [IDX_W-1:0]     element;
    logic [PRIO_BITS-1:0] key;
  } entry_t;

  // memory address of a 1-based slot or element number
  function automatic logic [ADDR_W-1:0] to_addr(logic [IDX_W-1:0] n);
    logic [IDX_W-1:0] t;
    t = n - IDX_W'(1);
    return t[ADDR_W-1:0];
  endfunction

endpackage

### sv/indexed_min_heap.sv
// Indexed binary min-heap of up to 1024 elements with 32-bit priorities.
// Input channel in_valid_i / in_stall_o carries one request: clear, decrease
// key, delete minimum or query. Output channel out_valid_o / out_stall_i
// returns one result per request with the root and an empty flag.
// cfg_we_i / cfg_wdata_i write active_count, the heap size after a clear.
// One request is worked at a time; the next is taken in the cycle after the
// result is loaded into the output register, even while the receiver stalls.
// Work per request: a clear sweeps all 1024 entries; decrease key reads the
// slot and the key and then one parent per level climbed; delete minimum reads
// the root and the last slot and then the children per level descended (at most
// 9 levels); a query reads the slot and then the key. The heap memory has a
// single registered read port, one slot read per cycle.
// After reset the block sweeps all 1024 entries of both memories with in_stall_o
// high and then holds all elements at priority all ones in identity order.
// A stalled result holds in the output register; a finished request waits
// for that register before it is loaded.
module indexed_min_heap (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  imh_pkg::req_t              in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output imh_pkg::rsp_t              out_rsp_o,
  input  logic                       cfg_we_i,
  input  logic [imh_pkg::IDX_W-1:0]  cfg_wdata_i
);

  import imh_pkg::*;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_Q_POS, S_Q_KEY, S_DK_POS, S_DK_KEY, S_UP, S_UP_CMP,
    S_DM_ROOT, S_DM_LAST, S_DN, S_DN_L, S_DN_R, S_DN_CMP, S_FIN, S_OUT
  } state_e;

  localparam logic [IDX_W-1:0] MaxCount = IDX_W'(MAX_ELEMENTS);

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     active_q, active_d;
  logic [IDX_W-1:0]     live_q, live_d;
  logic [ADDR_W-1:0]    cnt_q, cnt_d;
  logic                 sweep_rsp_q, sweep_rsp_d;
  logic [IDX_W-1:0]     s_q, s_d;
  entry_t               held_q, held_d;
  entry_t               left_q, left_d;
  entry_t               right_q, right_d;
  logic                 has_r_q, has_r_d;
  logic                 applied_q, applied_d;
  logic [IDX_W-1:0]     rem_el_q, rem_el_d;
  logic [PRIO_BITS-1:0] rem_pr_q, rem_pr_d;
  logic [PRIO_BITS-1:0] el_pr_q, el_pr_d;
  logic                 out_valid_q, out_valid_d;
  rsp_t                 rsp_q, rsp_d;

  // memory ports
  logic              heap_we, heap_re, pos_we, pos_re;
  logic [ADDR_W-1:0] heap_waddr, heap_raddr, pos_waddr, pos_raddr;
  entry_t            heap_wdata, heap_rdata;
  logic [IDX_W-1:0]  pos_wdata, pos_rdata;

  logic             accept;
  logic             el_ok;
  logic [IDX_W:0]   two_s, two_s1;
  logic             pick_l, pick_r;
  logic [IDX_W-1:0] sweep_n;

  // heap slots (element and priority per slot) and slot of each element
  imh_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ELEMENTS)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .re_i    (heap_re),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata)
  );

  imh_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  assign el_ok   = (in_req_i.element != '0) && (in_req_i.element <= MaxCount);
  assign two_s   = {s_q, 1'b0};
  assign two_s1  = two_s + (IDX_W+1)'(1);
  assign sweep_n = {1'b0, cnt_q} + IDX_W'(1);

  // child selection for sift down: strict less-than, left wins ties
  assign pick_l = (left_q.key < held_q.key);
  assign pick_r = has_r_q &&
                  (right_q.key < (pick_l ? left_q.key : held_q.key));

  // next state, memory control and result fields
  always_comb begin
    state_d     = state_q;
    active_d    = cfg_we_i ? cfg_wdata_i : active_q;
    live_d      = live_q;
    cnt_d       = cnt_q;
    sweep_rsp_d = sweep_rsp_q;
    s_d         = s_q;
    held_d      = held_q;
    left_d      = left_q;
    right_d     = right_q;
    has_r_d     = has_r_q;
    applied_d   = applied_q;
    rem_el_d    = rem_el_q;
    rem_pr_d    = rem_pr_q;
    el_pr_d     = el_pr_q;
    out_valid_d = out_valid_q && out_stall_i;
    rsp_d       = rsp_q;
    heap_we     = 1'b0;
    heap_waddr  = '0;
    heap_wdata  = held_q;
    heap_re     = 1'b0;
    heap_raddr  = '0;
    pos_we      = 1'b0;
    pos_waddr   = '0;
    pos_wdata   = s_q;
    pos_re      = 1'b0;
    pos_raddr   = '0;

    unique case (state_q)
      // write identity maps and all-ones keys, one entry a cycle
      S_SWEEP: begin
        heap_we    = 1'b1;
        heap_waddr = cnt_q;
        heap_wdata = '{element: sweep_n, key: '1};
        pos_we     = 1'b1;
        pos_waddr  = cnt_q;
        pos_wdata  = sweep_n;
        cnt_d      = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(MAX_ELEMENTS - 1)) begin
          state_d = sweep_rsp_q ? S_FIN : S_IDLE;
        end
      end

      // take a request and dispatch on its op
      S_IDLE: begin
        if (accept) begin
          applied_d   = 1'b0;
          rem_el_d    = '0;
          rem_pr_d    = '0;
          el_pr_d     = '0;
          held_d      = '{element: in_req_i.element, key: in_req_i.new_priority};
          sweep_rsp_d = 1'b0;
          unique case (in_req_i.op)
            OP_CLEAR: begin
              applied_d   = 1'b1;
              live_d      = (active_q > MaxCount) ? MaxCount : active_q;
              cnt_d       = '0;
              sweep_rsp_d = 1'b1;
              state_d     = S_SWEEP;
            end
            OP_DEC_KEY: begin
              if (el_ok) begin
                pos_re    = 1'b1;
                pos_raddr = to_addr(in_req_i.element);
                state_d   = S_DK_POS;
              end else begin
                state_d = S_FIN;
              end
            end
            OP_DEL_MIN: begin
              if (live_q != '0) begin
                heap_re    = 1'b1;
                heap_raddr = '0;
                state_d    = S_DM_ROOT;
              end else begin
                state_d = S_FIN;
              end
            end
            OP_QUERY: begin
              if (el_ok) begin
                pos_re    = 1'b1;
                pos_raddr = to_addr(in_req_i.element);
                state_d   = S_Q_POS;
              end else begin
                state_d = S_FIN;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      // query: slot of the element, then its key
      S_Q_POS: begin
        heap_re    = 1'b1;
        heap_raddr = to_addr(pos_rdata);
        state_d    = S_Q_KEY;
      end
      S_Q_KEY: begin
        el_pr_d   = heap_rdata.key;
        applied_d = 1'b1;
        state_d   = S_FIN;
      end

      // decrease key: element must be live and the key must drop
      S_DK_POS: begin
        s_d = pos_rdata;
        if (pos_rdata > live_q) begin
          state_d = S_FIN;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = to_addr(pos_rdata);
          state_d    = S_DK_KEY;
        end
      end
      S_DK_KEY: begin
        if (held_q.key < heap_rdata.key) begin
          applied_d = 1'b1;
          state_d   = S_UP;
        end else begin
          state_d = S_FIN;
        end
      end

      // sift up: read parent or place the held element at the root
      S_UP: begin
        if (s_q == IDX_W'(1)) begin
          heap_we    = 1'b1;
          heap_waddr = '0;
          pos_we     = 1'b1;
          pos_waddr  = to_addr(held_q.element);
          state_d    = S_FIN;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = to_addr(s_q >> 1);
          state_d    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        heap_we    = 1'b1;
        heap_waddr = to_addr(s_q);
        pos_we     = 1'b1;
        if (held_q.key < heap_rdata.key) begin
          heap_wdata = heap_rdata;
          pos_waddr  = to_addr(heap_rdata.element);
          s_d        = s_q >> 1;
          state_d    = S_UP;
        end else begin
          pos_waddr = to_addr(held_q.element);
          state_d   = S_FIN;
        end
      end

      // delete min: fetch root, then last slot, and swap
      S_DM_ROOT: begin
        rem_el_d   = heap_rdata.element;
        rem_pr_d   = heap_rdata.key;
        applied_d  = 1'b1;
        heap_re    = 1'b1;
        heap_raddr = to_addr(live_q);
        state_d    = S_DM_LAST;
      end
      S_DM_LAST: begin
        held_d     = heap_rdata;
        heap_we    = 1'b1;
        heap_waddr = to_addr(live_q);
        heap_wdata = '{element: rem_el_q, key: rem_pr_q};
        pos_we     = 1'b1;
        pos_waddr  = to_addr(rem_el_q);
        pos_wdata  = live_q;
        live_d     = live_q - IDX_W'(1);
        s_d        = IDX_W'(1);
        state_d    = S_DN;
      end

      // sift down: read children, move the smaller one up
      S_DN: begin
        if (two_s > {1'b0, live_q}) begin
          heap_we    = 1'b1;
          heap_waddr = to_addr(s_q);
          pos_we     = 1'b1;
          pos_waddr  = to_addr(held_q.element);
          state_d    = S_FIN;
        end else begin
          heap_re    = 1'b1;
          heap_raddr = to_addr(two_s[IDX_W-1:0]);
          state_d    = S_DN_L;
        end
      end
      S_DN_L: begin
        left_d = heap_rdata;
        if (two_s1 <= {1'b0, live_q}) begin
          has_r_d    = 1'b1;
          heap_re    = 1'b1;
          heap_raddr = to_addr(two_s1[IDX_W-1:0]);
          state_d    = S_DN_R;
        end else begin
          has_r_d = 1'b0;
          state_d = S_DN_CMP;
        end
      end
      S_DN_R: begin
        right_d = heap_rdata;
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        heap_we    = 1'b1;
        heap_waddr = to_addr(s_q);
        pos_we     = 1'b1;
        if (pick_r) begin
          heap_wdata = right_q;
          pos_waddr  = to_addr(right_q.element);
          s_d        = two_s1[IDX_W-1:0];
          state_d    = S_DN;
        end else if (pick_l) begin
          heap_wdata = left_q;
          pos_waddr  = to_addr(left_q.element);
          s_d        = two_s[IDX_W-1:0];
          state_d    = S_DN;
        end else begin
          pos_waddr = to_addr(held_q.element);
          state_d   = S_FIN;
        end
      end

      // read the root for the result
      S_FIN: begin
        heap_re    = 1'b1;
        heap_raddr = '0;
        state_d    = S_OUT;
      end

      // load the output register once it is free
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d            = 1'b1;
          rsp_d.applied          = applied_q;
          rsp_d.is_empty         = (live_q == '0);
          rsp_d.min_element      = (live_q == '0) ? '0 : heap_rdata.element;
          rsp_d.root_priority    = (live_q == '0) ? '0 : heap_rdata.key;
          rsp_d.removed_element  = rem_el_q;
          rsp_d.removed_priority = rem_pr_q;
          rsp_d.element_priority = el_pr_q;
          state_d                = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      active_q    <= MaxCount;
      live_q      <= MaxCount;
      cnt_q       <= '0;
      sweep_rsp_q <= 1'b0;
      s_q         <= '0;
      held_q      <= '0;
      left_q      <= '0;
      right_q     <= '0;
      has_r_q     <= 1'b0;
      applied_q   <= 1'b0;
      rem_el_q    <= '0;
      rem_pr_q    <= '0;
      el_pr_q     <= '0;
      out_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      live_q      <= live_d;
      cnt_q       <= cnt_d;
      sweep_rsp_q <= sweep_rsp_d;
      s_q         <= s_d;
      held_q      <= held_d;
      left_q      <= left_d;
      right_q     <= right_d;
      has_r_q     <= has_r_d;
      applied_q   <= applied_d;
      rem_el_q    <= rem_el_d;
      rem_pr_q    <= rem_pr_d;
      el_pr_q     <= el_pr_d;
      out_valid_q <= out_valid_d;
      rsp_q       <= rsp_d;
    end
  end

  // both maps are always updated together
  assert property (@(posedge clk_i) disable iff (!rst_ni) heap_we == pos_we)
    else $error("heap and slot map writes out of step");

  // heap size never exceeds the element space
  assert property (@(posedge clk_i) disable iff (!rst_ni) live_q <= MaxCount)
    else $error("live count above element space");

  // size changes only on a clear request or a delete-min swap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (live_q != $past(live_q)) |->
      ($past(state_q) == S_IDLE || $past(state_q) == S_DM_LAST))
    else $error("live count changed outside clear or delete");

  // a new result is loaded only from the output step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT)
    else $error("result shown without finishing a request");

  // a request that did nothing removed nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.applied) |-> out_rsp_o.removed_element == '0)
    else $error("removed element on an ignored request");

endmodule

### sv/imh_ram.sv
module imh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import imh_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 1200;
  localparam int unsigned HOLD_CYCLES    = 1600;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  req_t          in_req_i;
  logic          out_valid_o;
  logic          out_stall_i;
  rsp_t          out_rsp_o;
  logic          cfg_we_i;
  logic [IDX_W-1:0] cfg_wdata_i;

  indexed_min_heap dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // heap shadow state, 1-based
  logic [PRIO_BITS-1:0] prio_of [0:MAX_ELEMENTS];
  logic [IDX_W-1:0]     elem_at [0:MAX_ELEMENTS];
  logic [IDX_W-1:0]     pos_of  [0:MAX_ELEMENTS];
  int unsigned          heap_size;
  int unsigned          clear_size;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   error_count;
  bit   idle_off;
  bit   hold_active;
  int   hold_left;
  int   idle_left;
  int   quiet_cycles;

  function automatic void shadow_clear();
    for (int i = 0; i <= MAX_ELEMENTS; i++) begin
      prio_of[i] = '1;
      elem_at[i] = IDX_W'(i);
      pos_of[i]  = IDX_W'(i);
    end
    heap_size = clear_size;
  endfunction

  function automatic void shadow_swap(int unsigned a, int unsigned b);
    logic [IDX_W-1:0] t;
    t = elem_at[a];
    elem_at[a] = elem_at[b];
    elem_at[b] = t;
    pos_of[elem_at[a]] = IDX_W'(a);
    pos_of[elem_at[b]] = IDX_W'(b);
  endfunction

  // compute the result of one request and update the shadow heap
  function automatic rsp_t heap_apply(req_t r);
    rsp_t o;
    int unsigned s, l, pick;
    bit ok;
    logic [IDX_W-1:0] e;
    o = '0;
    e = r.element;
    ok = (e >= 1) && (e <= MAX_ELEMENTS);
    case (r.op)
      OP_CLEAR: begin
        shadow_clear();
        o.applied = 1'b1;
      end
      OP_DEC_KEY: begin
        if (ok && pos_of[e] <= heap_size && r.new_priority < prio_of[e]) begin
          prio_of[e] = r.new_priority;
          s = pos_of[e];
          while (s > 1 && prio_of[elem_at[s]] < prio_of[elem_at[s/2]]) begin
            shadow_swap(s, s / 2);
            s = s / 2;
          end
          o.applied = 1'b1;
        end
      end
      OP_DEL_MIN: begin
        if (heap_size > 0) begin
          shadow_swap(1, heap_size);
          heap_size--;
          s = 1;
          while (2 * s <= heap_size) begin
            l = 2 * s;
            pick = s;
            if (prio_of[elem_at[l]] < prio_of[elem_at[s]]) pick = l;
            if (l + 1 <= heap_size && prio_of[elem_at[l+1]] < prio_of[elem_at[pick]])
              pick = l + 1;
            if (pick == s) break;
            shadow_swap(s, pick);
            s = pick;
          end
          o.removed_element  = elem_at[heap_size+1];
          o.removed_priority = prio_of[elem_at[heap_size+1]];
          o.applied = 1'b1;
        end
      end
      default: begin
        if (ok) begin
          o.element_priority = prio_of[e];
          o.applied = 1'b1;
        end
      end
    endcase
    if (heap_size > 0) begin
      o.min_element   = elem_at[1];
      o.root_priority = prio_of[elem_at[1]];
    end else begin
      o.is_empty = 1'b1;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // driver with idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      idle_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        void'(pending_reqs.pop_front());
        expected_rsps.push_back(heap_apply(in_req_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (!idle_off && idle_left > 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 7) == 0) begin
          idle_left = $urandom_range(0, 15);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          in_req_i   <= pending_reqs[0];
        end
      end
    end
  end

  // receiver stall with bursts and one long hold
  int stall_burst;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_burst = 0;
      hold_left   = HOLD_CYCLES;
    end else if (hold_active && hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_burst > 0) begin
      stall_burst--;
      out_stall_i <= 1'b1;
    end else if (!idle_off && $urandom_range(0, 9) == 0) begin
      stall_burst = $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_rsp_o.min_element), 64'd0);
      end else begin
        want = expected_rsps.pop_front();
        if (out_rsp_o.applied !== want.applied)
          report_mismatch("applied", 64'(out_rsp_o.applied), 64'(want.applied));
        if (out_rsp_o.min_element !== want.min_element)
          report_mismatch("min_element", 64'(out_rsp_o.min_element), 64'(want.min_element));
        if (out_rsp_o.root_priority !== want.root_priority)
          report_mismatch("root_priority", 64'(out_rsp_o.root_priority),
                          64'(want.root_priority));
        if (out_rsp_o.is_empty !== want.is_empty)
          report_mismatch("is_empty", 64'(out_rsp_o.is_empty), 64'(want.is_empty));
        if (out_rsp_o.removed_element !== want.removed_element)
          report_mismatch("removed_element", 64'(out_rsp_o.removed_element),
                          64'(want.removed_element));
        if (out_rsp_o.removed_priority !== want.removed_priority)
          report_mismatch("removed_priority", 64'(out_rsp_o.removed_priority),
                          64'(want.removed_priority));
        if (out_rsp_o.element_priority !== want.element_priority)
          report_mismatch("element_priority", 64'(out_rsp_o.element_priority),
                          64'(want.element_priority));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic req_t make_req(op_e op, int unsigned e, logic [PRIO_BITS-1:0] p);
    req_t r;
    r.op = op;
    r.element = IDX_W'(e);
    r.new_priority = p;
    return r;
  endfunction

  // mostly live elements, sometimes invalid or out of range
  function automatic int unsigned pick_element(int unsigned span);
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k == 0) return 0;
    if (k == 1) return $urandom_range(MAX_ELEMENTS + 1, (1 << IDX_W) - 1);
    if (k == 2) return $urandom_range(1, MAX_ELEMENTS);
    return $urandom_range(1, span);
  endfunction

  function automatic logic [PRIO_BITS-1:0] pick_priority();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 31);
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(int unsigned v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= IDX_W'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    clear_size = (v > MAX_ELEMENTS) ? MAX_ELEMENTS : v;
  endtask

  task automatic random_phase(int unsigned n, int unsigned span);
    int unsigned k;
    pending_reqs.push_back(make_req(OP_CLEAR, 0, 0));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 5)
        pending_reqs.push_back(make_req(OP_DEC_KEY, pick_element(span), pick_priority()));
      else if (k < 8)
        pending_reqs.push_back(make_req(OP_DEL_MIN, $urandom_range(0, 2047), $urandom()));
      else if (k < 9)
        pending_reqs.push_back(make_req(OP_QUERY, pick_element(span), $urandom()));
      else
        pending_reqs.push_back(make_req(op_e'($urandom_range(0, 3)) == OP_CLEAR ?
                               OP_CLEAR : OP_QUERY, pick_element(span), $urandom()));
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    idle_off    = 1'b0;
    hold_active = 1'b0;
    error_count = 0;
    quiet_cycles = 0;
    clear_size  = MAX_ELEMENTS;
    shadow_clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset state, extremes, ties, invalid elements
    pending_reqs.push_back(make_req(OP_QUERY, 1, 0));
    pending_reqs.push_back(make_req(OP_QUERY, MAX_ELEMENTS, 0));
    pending_reqs.push_back(make_req(OP_QUERY, 0, 0));
    pending_reqs.push_back(make_req(OP_QUERY, 2047, 0));
    pending_reqs.push_back(make_req(OP_DEC_KEY, MAX_ELEMENTS, 32'h0000_0005));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 1000, 32'h0000_0005));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 500, 32'h0000_0006));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 3, '1));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 0, 0));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 1500, 0));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 7, 0));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 7, 0));
    pending_reqs.push_back(make_req(OP_DEL_MIN, 0, 0));
    pending_reqs.push_back(make_req(OP_DEL_MIN, 0, 0));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 7, 32'h0000_0001));
    pending_reqs.push_back(make_req(OP_QUERY, 7, 0));
    pending_reqs.push_back(make_req(OP_DEL_MIN, 2047, '1));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 2, 32'h7FFF_FFFF));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 3, 32'h7FFF_FFFF));
    pending_reqs.push_back(make_req(OP_DEL_MIN, 0, 0));
    pending_reqs.push_back(make_req(OP_QUERY, 1024, 0));
    wait_drained();

    // empty heap, then a count above the element space
    write_count(0);
    pending_reqs.push_back(make_req(OP_CLEAR, 0, 0));
    pending_reqs.push_back(make_req(OP_DEL_MIN, 0, 0));
    pending_reqs.push_back(make_req(OP_DEC_KEY, 1, 0));
    pending_reqs.push_back(make_req(OP_QUERY, 1, 0));
    wait_drained();
    write_count(2047);
    random_phase(10, MAX_ELEMENTS);
    wait_drained();

    // long receiver hold while requests keep coming
    write_count(5);
    random_phase(40, 6);
    hold_active = 1'b1;
    wait (hold_left == 0);
    hold_active = 1'b0;
    wait_drained();

    write_count(1);
    random_phase(30, 2);
    wait_drained();
    write_count(12);
    random_phase(180, 14);
    wait_drained();
    write_count(MAX_ELEMENTS);
    random_phase(100, 40);
    wait_drained();
    write_count($urandom_range(20, 200));
    idle_off = 1'b1;
    random_phase(160, 210);
    wait_drained();

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
